// ----- rtl/pns_pkg.sv -----
`timescale 1ns / 1ps
// pns_pkg: shared types and constants for the prime neighbor search core.
// No dependencies.
package pns_pkg;

  // Width of the value fields on the ports
  localparam int FIELD_W = 16;

  // Smallest prime; a downward search from a start value at or below it finds none
  localparam int FIRST_PRIME = 2;

  // Search direction codes
  localparam logic CMD_UP   = 1'b0;
  localparam logic CMD_DOWN = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CAND = 5'b00010,
    ST_INIT = 5'b00100,
    ST_TEST = 5'b01000,
    ST_DIV  = 5'b10000
  } pns_state_t;

  // Status returned by the remainder unit
  typedef struct packed {
    logic done;
    logic rem_zero;
  } pns_div_status_t;

endpackage

// ----- rtl/pns_rem_unit.sv -----
`timescale 1ns / 1ps
// pns_rem_unit: bit-serial restoring remainder unit, one quotient bit per cycle.
// Depends on pns_pkg.
module pns_rem_unit import pns_pkg::*; #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output pns_div_status_t  status
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic             running;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] dsr;
  logic [WIDTH:0]   trial;
  logic             ge;
  logic [WIDTH:0]   diff;

  // One restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem, quo[WIDTH-1]};
    ge    = trial >= {1'b0, dsr};
    diff  = trial - {1'b0, dsr};
  end

  // Control: step counter and done strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go && !running) begin
        running <= 1'b1;
        cnt     <= CNT_W'(WIDTH);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and dividend shifter
  always_ff @(posedge clk) begin
    if (go && !running) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (running) begin
      rem <= ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      quo <= {quo[WIDTH-2:0], 1'b0};
    end
  end

  assign status.done     = done;
  assign status.rem_zero = (rem == '0);

endmodule

// ----- rtl/prime_neighbor_search_core.sv -----
`timescale 1ns / 1ps
// prime_neighbor_search_core: nearest prime above or below a start value by
// trial division. Depends on pns_pkg and pns_rem_unit.
//
//  channel  | ports                            | beat marked by
//  ---------+----------------------------------+------------------
//  command  | command, start_value             | start && !busy
//  result   | prime_value, found               | done (one cycle)
//
// Each trial divisor is one pass through the shared remainder unit; a
// candidate tries divisors from 2 up to floor(sqrt(n)), a composite
// stopping at its first factor. An item costs the sum over the
// candidates stepped through until a prime or the end of the range.
// busy is high from the accepted beat until the result strobe.
// Synchronous reset returns the sequencer to idle; results cannot be stalled.
module prime_neighbor_search_core import pns_pkg::*; #(
  parameter int WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               command,
  input  logic [FIELD_W-1:0] start_value,
  output logic               done,
  output logic [FIELD_W-1:0] prime_value,
  output logic               found
);

  pns_state_t       state;
  logic             dir;
  logic [WIDTH-1:0] cand;
  logic [WIDTH-1:0] j;
  logic [WIDTH:0]   sq;
  logic             div_go;
  pns_div_status_t  div_status;

  logic [WIDTH+FIELD_W-1:0] start_ext;
  logic [WIDTH+FIELD_W-1:0] cand_ext;

  assign start_ext = {{WIDTH{1'b0}}, start_value};
  assign cand_ext  = {{FIELD_W{1'b0}}, cand};

  assign busy   = (state != ST_IDLE);
  assign div_go = (state == ST_TEST) && (sq <= {1'b0, cand});

  // Shared remainder unit: cand mod j
  pns_rem_unit #(.WIDTH(WIDTH)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (cand),
    .divisor  (j),
    .status   (div_status)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_CAND;
          end
        end
        ST_CAND: begin
          if (dir == CMD_UP) begin
            if (cand == {WIDTH{1'b1}}) begin
              state <= ST_IDLE;
              done  <= 1'b1;
            end else begin
              state <= ST_INIT;
            end
          end else begin
            if (cand <= WIDTH'(FIRST_PRIME)) begin
              state <= ST_IDLE;
              done  <= 1'b1;
            end else begin
              state <= ST_INIT;
            end
          end
        end
        ST_INIT: begin
          state <= (cand < WIDTH'(FIRST_PRIME)) ? ST_CAND : ST_TEST;
        end
        ST_TEST: begin
          if (div_go) begin
            state <= ST_DIV;
          end else begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        ST_DIV: begin
          if (div_status.done) begin
            state <= div_status.rem_zero ? ST_CAND : ST_TEST;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Candidate, divisor and divisor square
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        dir  <= command;
        cand <= start_ext[WIDTH-1:0];
      end
      ST_CAND: begin
        if (dir == CMD_UP) begin
          cand <= cand + 1'b1;
        end else begin
          cand <= cand - 1'b1;
        end
      end
      ST_INIT: begin
        j  <= WIDTH'(FIRST_PRIME);
        sq <= (WIDTH + 1)'(FIRST_PRIME * FIRST_PRIME);
      end
      ST_DIV: begin
        if (div_status.done && !div_status.rem_zero) begin
          j  <= j + 1'b1;
          sq <= sq + {j, 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (state == ST_CAND) begin
      prime_value <= '0;
      found       <= 1'b0;
    end else if (state == ST_TEST && !div_go) begin
      prime_value <= cand_ext[FIELD_W-1:0];
      found       <= 1'b1;
    end
  end

  // Checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted beat did not start a search");

  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (prime_value != '0)) else $error("found with zero value");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (prime_value == '0)) else $error("miss with nonzero value");

endmodule

// ----- dv/prime_neighbor_search_core_test.sv -----
`timescale 1ns / 1ps
// prime_neighbor_search_core_test: self-checking bench for the prime neighbor search core.
// Predicts each result by trial division and checks every result strobe against it.
// Depends on pns_pkg and prime_neighbor_search_core.
module prime_neighbor_search_core_test import pns_pkg::*;;

  localparam int WIDTH = 16;

  typedef struct {
    logic [FIELD_W-1:0] value;
    logic               found;
  } prime_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               command = CMD_UP;
  logic [FIELD_W-1:0] start_value = '0;
  logic               done;
  logic [FIELD_W-1:0] prime_value;
  logic               found;

  prime_beat_t       pending_primes[$];
  bit                allow_gaps = 1'b0;
  int                mismatches = 0;
  int                results_checked = 0;
  int                primes_found = 0;
  int                up_searches = 0;
  int                down_searches = 0;
  longint unsigned   search_work;
  longint unsigned   cycle_count = 0;
  longint unsigned   cycle_budget = 10_000;
  prime_beat_t       want;

  prime_neighbor_search_core #(.WIDTH(WIDTH)) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .start_value (start_value),
    .done        (done),
    .prime_value (prime_value),
    .found       (found)
  );

  always #4 clk = ~clk;

  // Trial division; work tallies roughly what the core spends on this candidate
  function automatic bit check_prime(input longint unsigned n, inout longint unsigned work);
    longint unsigned j;
    if (n < FIRST_PRIME) begin
      work += 3;
      return 1'b0;
    end
    for (j = FIRST_PRIME; j * j <= n; j++) begin
      work += WIDTH + 3;
      if (n % j == 0) begin
        work += 3;
        return 1'b0;
      end
    end
    work += 3;
    return 1'b1;
  endfunction

  // Nearest prime strictly above or below the start value, within WIDTH bits
  function automatic prime_beat_t nearest_prime(input logic cmd, input logic [FIELD_W-1:0] sv,
                                                inout longint unsigned work);
    prime_beat_t     r;
    longint unsigned top;
    longint unsigned c;
    r.value = '0;
    r.found = 1'b0;
    top = (longint'(1) << WIDTH) - 1;
    c = longint'(sv) & top;
    if (cmd == CMD_UP) begin
      for (c = c + 1; c <= top; c++) begin
        if (check_prime(c, work)) begin
          r.value = FIELD_W'(c);
          r.found = 1'b1;
          break;
        end
      end
    end else begin
      while (c > FIRST_PRIME) begin
        c--;
        if (check_prime(c, work)) begin
          r.value = FIELD_W'(c);
          r.found = 1'b1;
          break;
        end
      end
    end
    return r;
  endfunction

  // Command beat: predict the result and extend the cycle budget
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      search_work = 0;
      pending_primes.push_back(nearest_prime(command, start_value, search_work));
      cycle_budget += 4 * search_work + 256;
      if (command == CMD_UP) up_searches++;
      else down_searches++;
    end
  end

  // Result beat: compare with the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_primes.size() == 0) begin
        $error("unexpected result beat: prime_value=%0d found=%0b", prime_value, found);
        mismatches++;
      end else begin
        want = pending_primes.pop_front();
        results_checked++;
        if (found) primes_found++;
        if (prime_value !== want.value) begin
          $error("prime_value: expected %0d, got %0d", want.value, prime_value);
          mismatches++;
        end
        if (found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, found);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) cycle_count++;

  // Watchdog: budget grows with the predicted work of each accepted beat
  initial begin
    while (cycle_count <= cycle_budget) @(posedge clk);
    $display("timeout after %0d cycles", cycle_count);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // One command beat; start stays high afterwards unless a gap lowers it
  task automatic send_search(input logic cmd, input logic [FIELD_W-1:0] sv);
    if (allow_gaps && $urandom_range(99) < 30) begin
      start <= 1'b0;
      // half the gaps land after the core has gone idle
      if ($urandom_range(1)) begin
        do @(posedge clk); while (busy);
      end
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    start       <= 1'b1;
    command     <= cmd;
    start_value <= sv;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [FIELD_W-1:0] pick_start_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 60) return FIELD_W'($urandom_range(4095));
    if (sel < 85) return FIELD_W'($urandom_range(65535));
    if ($urandom_range(1)) return FIELD_W'($urandom_range(15));
    return FIELD_W'($urandom_range(65535, 65490));
  endfunction

  // Range ends, small values, and composites that a loose divisor test would pass
  task automatic test_directed_edges();
    allow_gaps = 1'b0;
    send_search(CMD_UP, 16'd0);
    send_search(CMD_UP, 16'd1);
    send_search(CMD_UP, 16'd2);
    send_search(CMD_UP, 16'd3);
    send_search(CMD_UP, 16'd8);
    send_search(CMD_UP, 16'd24);
    send_search(CMD_UP, 16'd65519);
    send_search(CMD_UP, 16'd65520);
    send_search(CMD_UP, 16'd65521);
    send_search(CMD_UP, 16'd65534);
    send_search(CMD_UP, 16'd65535);
    send_search(CMD_DOWN, 16'd0);
    send_search(CMD_DOWN, 16'd1);
    send_search(CMD_DOWN, 16'd2);
    send_search(CMD_DOWN, 16'd3);
    send_search(CMD_DOWN, 16'd4);
    send_search(CMD_DOWN, 16'd10);
    send_search(CMD_DOWN, 16'd26);
    send_search(CMD_DOWN, 16'd32768);
    send_search(CMD_DOWN, 16'd65521);
    send_search(CMD_DOWN, 16'd65522);
    send_search(CMD_DOWN, 16'd65535);
  endtask

  task automatic test_random_gaps();
    allow_gaps = 1'b1;
    repeat (88) send_search(logic'($urandom_range(1)), pick_start_value());
  endtask

  task automatic test_random_back_to_back();
    allow_gaps = 1'b0;
    repeat (30) send_search(logic'($urandom_range(1)), pick_start_value());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_edges();
    test_random_gaps();
    test_random_back_to_back();
    start <= 1'b0;
    while (pending_primes.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("searched %0d times (%0d up, %0d down) over range ends and random values;",
             up_searches + down_searches, up_searches, down_searches);
    $display("%0d results checked, %0d with a prime found", results_checked, primes_found);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
